>>> hw/rtl/fcfv_pkg.sv
// Shared types, widths and step functions for the floor collision pipeline.
// No dependencies; used by every module of the block.
package fcfv_pkg;

	localparam int VelW      = 32;
	localparam int MuW       = 16;
	localparam int MuFrac    = 12;
	localparam int SqW       = 2 * VelW;
	localparam int SqrtSteps = VelW;
	localparam int DivSteps  = VelW;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_STUCK = 2'd1,
		KIND_SLIDE = 2'd2
	} contact_kind_t;

	// per-node payload carried down the pipe
	typedef struct packed {
		logic [VelW-1:0] vx;
		logic [VelW-1:0] vy;
		logic [VelW-1:0] vz;
		logic            collide;
		logic            stick;
		logic [VelW-1:0] thr;
		logic [VelW-1:0] ax;
		logic [VelW-1:0] ay;
	} node_t;

	typedef struct packed {
		logic [VelW+2:0] rem;
		logic [VelW-1:0] root;
		logic [SqW-1:0]  rad;
	} sqrt_t;

	typedef struct packed {
		logic [VelW-1:0] rem;
		logic [VelW-1:0] quo;
		logic [VelW-1:0] low;
	} div_t;

	// one radix-4 digit of the integer square root
	function automatic sqrt_t sqrt_step(sqrt_t a);
		sqrt_t r;
		logic [VelW+2:0] cur;
		logic [VelW+2:0] trial;
		cur   = {a.rem[VelW:0], a.rad[SqW-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {a.root[VelW-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {a.root[VelW-2:0], 1'b0};
		end
		r.rad = {a.rad[SqW-3:0], 2'b00};
		return r;
	endfunction

	// one quotient bit of restoring division
	function automatic div_t div_step(div_t a, logic [VelW-1:0] d);
		div_t r;
		logic [VelW:0] cur;
		cur = {a.rem, a.low[VelW-1]};
		if (cur >= {1'b0, d}) begin
			cur   = cur - {1'b0, d};
			r.quo = {a.quo[VelW-2:0], 1'b1};
		end else begin
			r.quo = {a.quo[VelW-2:0], 1'b0};
		end
		r.rem = cur[VelW-1:0];
		r.low = {a.low[VelW-2:0], 1'b0};
		return r;
	endfunction

endpackage

>>> hw/rtl/floor_collision_friction_velocity_top.sv
// Top level of the floor collision / Coulomb friction velocity pipeline.
// Depends on fcfv_pkg, fcfv_front, fcfv_sqrt, fcfv_scale.
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: height_z, vel_in_x, vel_in_y, vel_in_z
// m_*       out  tvalid/tready      tdata: vel_out_x/y/z, tuser: contact_kind
// cfg_*     in   cfg_we             cfg_index 0 floor_height, 1 friction_coeff
//
// One node per cycle while the output is not stalled; 5 front stages, 32 square root
// digit stages, 2 scale stages, 32 divider stages and the output register.
// Reset clears all stage valids and loads floor 6554 and mu 4096.
// Whole pipe advances when the output register is empty or taken.
module floor_collision_friction_velocity_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // height_z, vel_in_x, vel_in_y, vel_in_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // vel_out_x, vel_out_y, vel_out_z
	output logic [1:0]   m_tuser,   // contact_kind
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam logic CfgFloor = 1'b0;
	localparam logic CfgMu    = 1'b1;
	localparam int   W        = fcfv_pkg::VelW;

	logic [W-1:0]                 floor_q;
	logic [fcfv_pkg::MuW-1:0]     mu_q;
	logic                         en;
	logic                         f_valid, r_valid;
	fcfv_pkg::node_t              f_node, r_node;
	logic [fcfv_pkg::SqW-1:0]     f_sumsq;
	logic [W-1:0]                 r_len;
	logic [W-1:0]                 ox, oy, oz;
	fcfv_pkg::contact_kind_t      kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= W'(6554);
			mu_q    <= fcfv_pkg::MuW'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgFloor: floor_q <= cfg_data;
				CfgMu:    mu_q    <= cfg_data[fcfv_pkg::MuW-1:0];
				default:  ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	fcfv_front u_front (
		.clk, .arst_n, .en,
		.in_valid       (s_tvalid),
		.height_z       (s_tdata[31:0]),
		.vel_in_x       (s_tdata[63:32]),
		.vel_in_y       (s_tdata[95:64]),
		.vel_in_z       (s_tdata[127:96]),
		.floor_height   (floor_q),
		.friction_coeff (mu_q),
		.out_valid      (f_valid),
		.out_node       (f_node),
		.out_sumsq      (f_sumsq)
	);

	fcfv_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid  (f_valid),
		.in_node   (f_node),
		.in_sumsq  (f_sumsq),
		.out_valid (r_valid),
		.out_node  (r_node),
		.out_len   (r_len)
	);

	fcfv_scale u_scale (
		.clk, .arst_n, .en,
		.in_valid     (r_valid),
		.in_node      (r_node),
		.in_len       (r_len),
		.out_valid    (m_tvalid),
		.vel_out_x    (ox),
		.vel_out_y    (oy),
		.vel_out_z    (oz),
		.contact_kind (kind)
	);

	assign m_tdata = {oz, oy, ox};
	assign m_tuser = kind;

	a_stuck_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fcfv_pkg::KIND_STUCK |-> m_tdata == '0)
		else $error("stuck node with nonzero velocity");

	a_slide_z: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fcfv_pkg::KIND_SLIDE |-> m_tdata[95:64] == '0)
		else $error("sliding node with nonzero normal velocity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready ##1
		(m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed or pipe advanced");
endmodule

>>> hw/rtl/fcfv_front.sv
// Front stages: contact test, friction threshold, squared lengths, stick test.
// Depends on fcfv_pkg.
module fcfv_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [fcfv_pkg::VelW-1:0]       height_z,
	input  logic [fcfv_pkg::VelW-1:0]       vel_in_x,
	input  logic [fcfv_pkg::VelW-1:0]       vel_in_y,
	input  logic [fcfv_pkg::VelW-1:0]       vel_in_z,
	input  logic [fcfv_pkg::VelW-1:0]       floor_height,
	input  logic [fcfv_pkg::MuW-1:0]        friction_coeff,
	output logic                            out_valid,
	output fcfv_pkg::node_t                 out_node,
	output logic [fcfv_pkg::SqW-1:0]        out_sumsq
);
	localparam int ThrW = fcfv_pkg::MuW + fcfv_pkg::VelW;

	logic                            v_s1, v_s2, v_s3, v_s4, v_s5;
	fcfv_pkg::node_t                 n_s1, n_s2, n_s3, n_s4, n_s5;
	fcfv_pkg::node_t                 n_in, n_thr, n_stk;
	logic [fcfv_pkg::VelW-1:0]       down_s1;
	logic [fcfv_pkg::MuW-1:0]        mu_s1;
	logic [ThrW-1:0]                 thrf_s2;
	logic [fcfv_pkg::SqW-1:0]        sqx_s2, sqy_s2, sum_s3, sum_s4, sum_s5, thr2_s4;
	logic                            big_s3, big_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_comb begin
		n_in         = '0;
		n_in.vx      = vel_in_x;
		n_in.vy      = vel_in_y;
		n_in.vz      = vel_in_z;
		n_in.collide = ($signed(height_z) <= $signed(floor_height)) &&
		               vel_in_z[fcfv_pkg::VelW-1];
		n_in.ax      = vel_in_x[fcfv_pkg::VelW-1] ? -vel_in_x : vel_in_x;
		n_in.ay      = vel_in_y[fcfv_pkg::VelW-1] ? -vel_in_y : vel_in_y;

		n_thr     = n_s2;
		n_thr.thr = thrf_s2[fcfv_pkg::MuFrac +: fcfv_pkg::VelW];

		n_stk       = n_s4;
		n_stk.stick = big_s4 || (sum_s4 <= thr2_s4);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= n_in;
			down_s1 <= -vel_in_z;
			mu_s1   <= friction_coeff;

			n_s2    <= n_s1;
			thrf_s2 <= ThrW'(mu_s1) * ThrW'(down_s1);
			sqx_s2  <= fcfv_pkg::SqW'(n_s1.ax) * fcfv_pkg::SqW'(n_s1.ax);
			sqy_s2  <= fcfv_pkg::SqW'(n_s1.ay) * fcfv_pkg::SqW'(n_s1.ay);

			n_s3   <= n_thr;
			big_s3 <= |thrf_s2[ThrW-1:fcfv_pkg::MuFrac+fcfv_pkg::VelW];
			sum_s3 <= sqx_s2 + sqy_s2;

			n_s4    <= n_s3;
			big_s4  <= big_s3;
			sum_s4  <= sum_s3;
			thr2_s4 <= fcfv_pkg::SqW'(n_s3.thr) * fcfv_pkg::SqW'(n_s3.thr);

			n_s5   <= n_stk;
			sum_s5 <= sum_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_node  = n_s5;
	assign out_sumsq = sum_s5;
endmodule

>>> hw/rtl/fcfv_sqrt.sv
// Pipelined integer square root of the tangential length squared, one digit a stage.
// Depends on fcfv_pkg.
module fcfv_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  fcfv_pkg::node_t            in_node,
	input  logic [fcfv_pkg::SqW-1:0]   in_sumsq,
	output logic                       out_valid,
	output fcfv_pkg::node_t            out_node,
	output logic [fcfv_pkg::VelW-1:0]  out_len
);
	localparam int N = fcfv_pkg::SqrtSteps;

	logic            v_s  [N];
	fcfv_pkg::node_t n_s  [N];
	fcfv_pkg::sqrt_t sq_s [N];
	fcfv_pkg::sqrt_t seed;

	always_comb begin
		seed      = '0;
		seed.rad  = in_sumsq;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= (k == 0) ? in_valid : v_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					n_s[k]  <= in_node;
					sq_s[k] <= fcfv_pkg::sqrt_step(seed);
				end else begin
					n_s[k]  <= n_s[(k == 0) ? 0 : k-1];
					sq_s[k] <= fcfv_pkg::sqrt_step(sq_s[(k == 0) ? 0 : k-1]);
				end
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_node  = n_s[N-1];
	assign out_len   = sq_s[N-1].root;
endmodule

>>> hw/rtl/fcfv_scale.sv
// Slide scaling: keep = len - thr, products, two restoring dividers, output register.
// Depends on fcfv_pkg.
module fcfv_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  fcfv_pkg::node_t            in_node,
	input  logic [fcfv_pkg::VelW-1:0]  in_len,
	output logic                       out_valid,
	output logic [fcfv_pkg::VelW-1:0]  vel_out_x,
	output logic [fcfv_pkg::VelW-1:0]  vel_out_y,
	output logic [fcfv_pkg::VelW-1:0]  vel_out_z,
	output fcfv_pkg::contact_kind_t    contact_kind
);
	localparam int W = fcfv_pkg::VelW;
	localparam int N = fcfv_pkg::DivSteps;

	logic                     v_s1, v_s2, vo_q;
	fcfv_pkg::node_t          n_s1, n_s2;
	logic [W-1:0]             len_s1, len_s2, keep_s1;
	logic [fcfv_pkg::SqW-1:0] px_s2, py_s2;
	fcfv_pkg::div_t           seed_x, seed_y;

	logic            dv_s [N];
	fcfv_pkg::node_t dn_s [N];
	logic [W-1:0]    dd_s [N];
	fcfv_pkg::div_t  dx_s [N];
	fcfv_pkg::div_t  dy_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1    <= in_node;
			len_s1  <= in_len;
			keep_s1 <= in_len - in_node.thr;
			n_s2    <= n_s1;
			len_s2  <= len_s1;
			px_s2   <= fcfv_pkg::SqW'(n_s1.ax) * fcfv_pkg::SqW'(keep_s1);
			py_s2   <= fcfv_pkg::SqW'(n_s1.ay) * fcfv_pkg::SqW'(keep_s1);
		end
	end

	// upper half of the product is below len whenever the node slides
	always_comb begin
		seed_x.rem = px_s2[fcfv_pkg::SqW-1:W];
		seed_x.low = px_s2[W-1:0];
		seed_x.quo = '0;
		seed_y.rem = py_s2[fcfv_pkg::SqW-1:W];
		seed_y.low = py_s2[W-1:0];
		seed_y.quo = '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k] <= 1'b0;
			end else if (en) begin
				dv_s[k] <= (k == 0) ? v_s2 : dv_s[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					dn_s[k] <= n_s2;
					dd_s[k] <= len_s2;
					dx_s[k] <= fcfv_pkg::div_step(seed_x, len_s2);
					dy_s[k] <= fcfv_pkg::div_step(seed_y, len_s2);
				end else begin
					dn_s[k] <= dn_s[(k == 0) ? 0 : k-1];
					dd_s[k] <= dd_s[(k == 0) ? 0 : k-1];
					dx_s[k] <= fcfv_pkg::div_step(dx_s[(k == 0) ? 0 : k-1],
					                              dd_s[(k == 0) ? 0 : k-1]);
					dy_s[k] <= fcfv_pkg::div_step(dy_s[(k == 0) ? 0 : k-1],
					                              dd_s[(k == 0) ? 0 : k-1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= dv_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!dn_s[N-1].collide) begin
				vel_out_x    <= dn_s[N-1].vx;
				vel_out_y    <= dn_s[N-1].vy;
				vel_out_z    <= dn_s[N-1].vz;
				contact_kind <= fcfv_pkg::KIND_NONE;
			end else if (dn_s[N-1].stick) begin
				vel_out_x    <= '0;
				vel_out_y    <= '0;
				vel_out_z    <= '0;
				contact_kind <= fcfv_pkg::KIND_STUCK;
			end else begin
				vel_out_x    <= dn_s[N-1].vx[W-1] ? -dx_s[N-1].quo : dx_s[N-1].quo;
				vel_out_y    <= dn_s[N-1].vy[W-1] ? -dy_s[N-1].quo : dy_s[N-1].quo;
				vel_out_z    <= '0;
				contact_kind <= fcfv_pkg::KIND_SLIDE;
			end
		end
	end

	assign out_valid = vo_q;
endmodule

>>> sim/floor_collision_friction_velocity_top_tb.sv
// Self-checking testbench for the floor collision / Coulomb friction pipeline.
// Depends on fcfv_pkg and floor_collision_friction_velocity_top; stream in, stream out.
module floor_collision_friction_velocity_top_tb;

	typedef struct {
		logic [31:0]             vx;
		logic [31:0]             vy;
		logic [31:0]             vz;
		fcfv_pkg::contact_kind_t kind;
	} vel_res_t;

	typedef struct {
		logic [31:0] z;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		bit          known;
		vel_res_t    res;
	} node_row_t;

	localparam int NumPhases = 6;
	localparam int ItemsPerPhase = 280;
	localparam int DrainCycles = 90;
	localparam int StallLimit = 3000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_index = 1'b0;
	logic [31:0]  cfg_data = '0;

	logic signed [31:0] floor_q;
	logic [15:0]        mu_q;
	vel_res_t           pending_vel[$];
	int                 fails = 0;
	bit                 calm = 1'b0;
	bit                 moved = 1'b0;
	int                 stall_cnt = 0;
	node_row_t          rows[10];

	floor_collision_friction_velocity_top dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] shrink(logic signed [31:0] v, longint unsigned keep,
			longint unsigned len);
		longint unsigned mag;
		longint unsigned q;
		mag = v < 0 ? 64'(-64'(v)) : 64'(v);
		q = (mag * keep) / len;
		return v < 0 ? 32'(-q) : 32'(q);
	endfunction

	function automatic vel_res_t collide_response(logic signed [31:0] z, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz);
		vel_res_t r;
		longint unsigned down, thr, ax, ay, sumsq, len;
		r.vx = vx;
		r.vy = vy;
		r.vz = vz;
		r.kind = fcfv_pkg::KIND_NONE;
		if (z <= floor_q && vz < 0) begin
			down = 64'(-64'(vz));
			thr = (64'(mu_q) * down) >> fcfv_pkg::MuFrac;
			ax = vx < 0 ? 64'(-64'(vx)) : 64'(vx);
			ay = vy < 0 ? 64'(-64'(vy)) : 64'(vy);
			sumsq = ax * ax + ay * ay;
			r.vz = '0;
			if (thr >= 64'h1_0000_0000 || sumsq <= thr * thr) begin
				r.vx = '0;
				r.vy = '0;
				r.kind = fcfv_pkg::KIND_STUCK;
			end else begin
				len = isqrt(sumsq);
				r.vx = shrink(vx, len - thr, len);
				r.vy = shrink(vy, len - thr, len);
				r.kind = fcfv_pkg::KIND_SLIDE;
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom) >>> $urandom_range(31));
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom) >>> $urandom_range(24, 8));
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == 1'b0) floor_q = val;
		else mu_q = val[15:0];
		@(posedge clk);
	endtask

	// known: expectation given by the row, else predicted
	task automatic send_node(input logic [31:0] z, vx, vy, vz, input bit known,
			input vel_res_t res);
		bit taken;
		while (!calm && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {vz, vy, vx, z};
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken) begin
				moved = 1'b1;
				pending_vel.push_back(known ? res : collide_response(z, vx, vy, vz));
			end
			@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_vel.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	always @(posedge clk) m_tready <= calm || $urandom_range(99) >= 36;

	always @(negedge clk) begin
		vel_res_t e;
		if (m_tvalid && m_tready) begin
			moved = 1'b1;
			if (pending_vel.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				e = pending_vel.pop_front();
				if (m_tdata[31:0] !== e.vx) begin
					$error("vel_out_x exp %h got %h", e.vx, m_tdata[31:0]); fails++;
				end
				if (m_tdata[63:32] !== e.vy) begin
					$error("vel_out_y exp %h got %h", e.vy, m_tdata[63:32]); fails++;
				end
				if (m_tdata[95:64] !== e.vz) begin
					$error("vel_out_z exp %h got %h", e.vz, m_tdata[95:64]); fails++;
				end
				if (m_tuser !== e.kind) begin
					$error("contact_kind exp %0d got %0d", e.kind, m_tuser); fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (moved) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		moved = 1'b0;
		if (stall_cnt >= StallLimit) begin
			$display("floor_collision_friction_velocity_top regression: fail");
			$finish;
		end
	end

	initial begin
		vel_res_t none;
		logic [31:0] z, vx, vy, vz;
		none = '{default: '0, kind: fcfv_pkg::KIND_NONE};
		floor_q = 6554;
		mu_q = 16'd4096;
		// above floor, not moving down, stuck at rest, stuck on exact circle, extremes
		rows[0] = '{32'h7FFF_FFFF, 1, 2, -3, 1, '{1, 2, -3, fcfv_pkg::KIND_NONE}};
		rows[1] = '{32'h8000_0000, 5, 6, 0, 1, '{5, 6, 0, fcfv_pkg::KIND_NONE}};
		rows[2] = '{6554, 0, 0, -65536, 1, '{0, 0, 0, fcfv_pkg::KIND_STUCK}};
		rows[3] = '{32'h8000_0000, 3, 4, -5, 1, '{0, 0, 0, fcfv_pkg::KIND_STUCK}};
		// floor(sqrt(34)) equals the threshold: slides with nothing left
		rows[4] = '{0, 3, 5, -5, 1, '{0, 0, 0, fcfv_pkg::KIND_SLIDE}};
		rows[5] = '{6555, 7, 8, -9, 1, '{7, 8, -9, fcfv_pkg::KIND_NONE}};
		rows[6] = '{0, 32'h7FFF_FFFF, 32'h8000_0000, -1, 0, none};
		rows[7] = '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, none};
		rows[8] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000, 0, none};
		rows[9] = '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, none};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_node(rows[i].z, rows[i].vx, rows[i].vy, rows[i].vz, rows[i].known,
				rows[i].res);
		for (int p = 0; p < NumPhases; p++) begin
			if (p > 0) begin
				s_tvalid <= 1'b0;
				wait_drained();
				case (p)
					1: begin write_reg(1'b0, 32'h8000_0000); write_reg(1'b1, 32'd0); end
					2: begin write_reg(1'b0, 32'h7FFF_FFFF); write_reg(1'b1, 32'h0000_FFFF); end
					3: begin write_reg(1'b0, 32'd0); write_reg(1'b1, 32'd0); end
					default: begin
						write_reg(1'b0, $urandom);
						write_reg(1'b1, $urandom_range(16'hFFFF));
					end
				endcase
			end
			calm = (p == 2);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				vx = rand_vel();
				vy = rand_vel();
				vz = rand_vel();
				if ($urandom_range(9) < 7 && vz[31] == 1'b0) vz = -vz;
				case ($urandom_range(5))
					0: z = $urandom;
					1: z = floor_q;
					2: z = floor_q + 1;
					default: z = floor_q - $urandom_range(1000);
				endcase
				if (p == 1 && $urandom_range(3) == 0) z = 32'h8000_0000;
				send_node(z, vx, vy, vz, 1'b0, none);
			end
			calm = 1'b0;
		end
		s_tvalid <= 1'b0;
		wait_drained();
		if (fails == 0) begin
			$display("floor_collision_friction_velocity_top regression: pass");
		end else begin
			$display("floor_collision_friction_velocity_top regression: fail");
		end
		$finish;
	end

endmodule
